// File: src/llrp_pkg.sv
// Shared constants for the least-loaded row packer.
// Field widths, configuration register indexes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package llrp_pkg;

  // Parameter defaults
  localparam int MAX_ROWS_DEF   = 16;
  localparam int WIDTH_BITS_DEF = 16;

  // Port field widths
  localparam int GLYPH_W     = 12;
  localparam int ROW_CHOSEN_W = 4;
  localparam int ROW_WIDTH_W = 16;
  localparam int ROW_COUNT_W = 5;
  localparam int PAD_W       = 8;
  localparam int CFG_IDX_W   = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 4'd0,
    REG_PAD_WIDTH = 4'd1
  } cfg_reg_t;

endpackage

// File: src/least_loaded_row_packer.sv
// Least-loaded row packer: assigns each glyph to the narrowest active row.
// Uses llrp_pkg for field widths, register indexes and defaults.
// An accepted input beat passes the input register, then the result register.
// Throughput: one glyph per cycle while out_stall allows; the argmin tree over the row
// registers, the saturating add and the row update all sit between the input register
// and the result register, so back-to-back glyphs see the updated rows.
// Reset (rst_n low, synchronous): no beats in flight, row_count 1, pad 0,
// next glyph opens a fresh set.
`timescale 1ns / 1ps

module least_loaded_row_packer #(
  parameter int MAX_ROWS   = llrp_pkg::MAX_ROWS_DEF,
  parameter int WIDTH_BITS = llrp_pkg::WIDTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [llrp_pkg::GLYPH_W-1:0]        in_glyph_width,
  input  logic                                in_last_glyph,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [llrp_pkg::ROW_CHOSEN_W-1:0]   out_row_chosen,
  output logic [llrp_pkg::ROW_WIDTH_W-1:0]    out_row_width_after,
  output logic [llrp_pkg::ROW_WIDTH_W-1:0]    out_max_row_width,
  output logic                                out_final_flag,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [llrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int LVLS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 0;
  localparam int N2    = 1 << LVLS;
  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ACT_W = $clog2(MAX_ROWS + 1);
  localparam int KEY_W = WIDTH_BITS + 1;
  localparam int SUM_W = ((WIDTH_BITS > llrp_pkg::GLYPH_W) ? WIDTH_BITS
                                                           : llrp_pkg::GLYPH_W) + 2;

  // Configuration registers
  logic [llrp_pkg::ROW_COUNT_W-1:0] row_count_r;
  logic [llrp_pkg::PAD_W-1:0]       pad_width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= llrp_pkg::ROW_COUNT_W'(1);
      pad_width_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == llrp_pkg::REG_ROW_COUNT) begin
        row_count_r <= cfg_data[llrp_pkg::ROW_COUNT_W-1:0];
      end else if (cfg_index == llrp_pkg::REG_PAD_WIDTH) begin
        pad_width_r <= cfg_data[llrp_pkg::PAD_W-1:0];
      end
    end
  end

  // Handshake: the input register advances whenever the result register can load
  logic in_vld_r;
  logic out_vld_r;
  logic out_load;
  logic step;

  assign out_load  = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !out_load;
  assign step      = in_vld_r && out_load;
  assign out_valid = out_vld_r;

  // Input register
  logic [llrp_pkg::GLYPH_W-1:0] glyph_r;
  logic                         last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      glyph_r <= in_glyph_width;
      last_r  <= in_last_glyph;
    end
  end

  // Set state
  logic                  fresh_r;
  logic [ACT_W-1:0]      active_r;
  logic [llrp_pkg::PAD_W-1:0] set_pad_r;
  logic [WIDTH_BITS-1:0] rows_r [MAX_ROWS];
  logic [WIDTH_BITS-1:0] max_r;

  // Row count clamped to 1..MAX_ROWS
  logic [7:0]       rc_ext;
  logic [ACT_W-1:0] act_clamp;

  always_comb begin
    rc_ext = 8'(row_count_r);
    if (rc_ext == 8'd0) begin
      act_clamp = ACT_W'(1);
    end else if (rc_ext > 8'(MAX_ROWS)) begin
      act_clamp = ACT_W'(MAX_ROWS);
    end else begin
      act_clamp = ACT_W'(rc_ext);
    end
  end

  // Effective state for this beat: a fresh set loads every active row with pad
  logic [ACT_W-1:0]           act_eff;
  logic [llrp_pkg::PAD_W-1:0] pad_eff;
  logic [WIDTH_BITS-1:0]      pad_w;
  logic [WIDTH_BITS-1:0]      rows_eff [MAX_ROWS];
  logic [WIDTH_BITS-1:0]      max_eff;

  always_comb begin
    act_eff = fresh_r ? act_clamp : active_r;
    pad_eff = fresh_r ? pad_width_r : set_pad_r;
    pad_w   = WIDTH_BITS'(pad_eff);
    max_eff = fresh_r ? pad_w : max_r;
    for (int i = 0; i < MAX_ROWS; i++) begin
      if (fresh_r) begin
        rows_eff[i] = (ACT_W'(i) < act_eff) ? pad_w : '0;
      end else begin
        rows_eff[i] = rows_r[i];
      end
    end
  end

  // Argmin tree; inactive rows carry a set top bit, ties keep the lower index
  logic [KEY_W-1:0] key_a [LVLS+1][N2];
  logic [IDX_W-1:0] idx_a [LVLS+1][N2];

  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int j = 0; j < N2; j++) begin
        key_a[l][j] = {1'b1, {WIDTH_BITS{1'b0}}};
        idx_a[l][j] = '0;
      end
    end
    for (int i = 0; i < MAX_ROWS; i++) begin
      key_a[0][i] = {!(ACT_W'(i) < act_eff), rows_eff[i]};
      idx_a[0][i] = IDX_W'(i);
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < N2 / 2; j++) begin
        if (j < (N2 >> (l + 1))) begin
          if (key_a[l][2*j+1] < key_a[l][2*j]) begin
            key_a[l+1][j] = key_a[l][2*j+1];
            idx_a[l+1][j] = idx_a[l][2*j+1];
          end else begin
            key_a[l+1][j] = key_a[l][2*j];
            idx_a[l+1][j] = idx_a[l][2*j];
          end
        end
      end
    end
  end

  // Saturating add of glyph and pad onto the chosen row
  logic [IDX_W-1:0]      best;
  logic [SUM_W-1:0]      sum_raw;
  logic [WIDTH_BITS-1:0] sum_sat;
  logic [WIDTH_BITS-1:0] max_nxt;

  always_comb begin
    best    = idx_a[LVLS][0];
    sum_raw = SUM_W'(key_a[LVLS][0][WIDTH_BITS-1:0]) + SUM_W'(glyph_r) + SUM_W'(pad_eff);
    if (sum_raw[SUM_W-1:WIDTH_BITS] != '0) begin
      sum_sat = '1;
    end else begin
      sum_sat = sum_raw[WIDTH_BITS-1:0];
    end
    // rows only grow, so the widest row is a running max
    max_nxt = (sum_sat > max_eff) ? sum_sat : max_eff;
  end

  // State update on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r   <= 1'b1;
      active_r  <= ACT_W'(1);
      set_pad_r <= '0;
    end else if (step) begin
      fresh_r   <= last_r;
      active_r  <= act_eff;
      set_pad_r <= pad_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      max_r <= max_nxt;
      for (int i = 0; i < MAX_ROWS; i++) begin
        rows_r[i] <= (IDX_W'(i) == best) ? sum_sat : rows_eff[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_row_chosen      <= llrp_pkg::ROW_CHOSEN_W'(best);
      out_row_width_after <= llrp_pkg::ROW_WIDTH_W'(sum_sat);
      out_max_row_width   <= last_r ? llrp_pkg::ROW_WIDTH_W'(max_nxt) : '0;
      out_final_flag      <= last_r;
    end
  end

endmodule

// File: tb/least_loaded_row_packer_tb.sv
// Self-checking testbench for least_loaded_row_packer: drives glyph beats and register
// writes, predicts each placement in a small checker class and compares every result beat.
// Depends on llrp_pkg and the least_loaded_row_packer RTL only.
`timescale 1ns / 1ps

module least_loaded_row_packer_tb;

  localparam int MAX_CYCLES  = 200000;
  localparam int LONG_HOLD   = 120;
  localparam int DRAIN_WAIT  = 4;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_BEATS = 55;
  localparam int MAX_SET_LEN = 40;
  localparam logic [llrp_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG =
    llrp_pkg::CFG_IDX_W'(llrp_pkg::REG_PAD_WIDTH + 1);
  localparam logic [llrp_pkg::GLYPH_W-1:0]     GLYPH_MAX = {llrp_pkg::GLYPH_W{1'b1}};
  localparam logic [llrp_pkg::ROW_WIDTH_W-1:0] ROW_SAT = {llrp_pkg::ROW_WIDTH_W{1'b1}};

  typedef struct packed {
    logic [llrp_pkg::ROW_CHOSEN_W-1:0] row;
    logic [llrp_pkg::ROW_WIDTH_W-1:0]  width;
    logic [llrp_pkg::ROW_WIDTH_W-1:0]  widest;
    logic                              closes;
  } placement_t;

  // Greedy placement predictor plus queue of placements not yet seen on the output
  class packing_checker;
    logic [llrp_pkg::ROW_WIDTH_W-1:0] rows [llrp_pkg::MAX_ROWS_DEF];
    logic                             fresh_set;
    int                               rows_in_set;
    logic [llrp_pkg::PAD_W-1:0]       pad_in_set;
    logic [llrp_pkg::ROW_COUNT_W-1:0] reg_rows;
    logic [llrp_pkg::PAD_W-1:0]       reg_pad;
    placement_t                       pending_placements[$];
    int glyphs, results, sets_closed, saturated, mismatches;

    function new();
      for (int i = 0; i < llrp_pkg::MAX_ROWS_DEF; i++) rows[i] = '0;
      fresh_set   = 1'b1;
      rows_in_set = 1;
      pad_in_set  = '0;
      reg_rows    = llrp_pkg::ROW_COUNT_W'(1);
      reg_pad     = '0;
      glyphs = 0; results = 0; sets_closed = 0; saturated = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [llrp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == llrp_pkg::REG_ROW_COUNT) reg_rows = data[llrp_pkg::ROW_COUNT_W-1:0];
      else if (idx == llrp_pkg::REG_PAD_WIDTH) reg_pad = data[llrp_pkg::PAD_W-1:0];
    endfunction

    function void note_glyph(logic [llrp_pkg::GLYPH_W-1:0] w, logic last);
      int best;
      logic [llrp_pkg::ROW_WIDTH_W+1:0] sum;
      placement_t p;
      // registers are latched when a set opens
      if (fresh_set) begin
        if (reg_rows == 0) rows_in_set = 1;
        else if (reg_rows > llrp_pkg::MAX_ROWS_DEF) rows_in_set = llrp_pkg::MAX_ROWS_DEF;
        else rows_in_set = reg_rows;
        pad_in_set = reg_pad;
        for (int i = 0; i < llrp_pkg::MAX_ROWS_DEF; i++)
          rows[i] = (i < rows_in_set) ? llrp_pkg::ROW_WIDTH_W'(pad_in_set) : '0;
        fresh_set = 1'b0;
      end
      // narrowest row, lowest index on a tie
      best = 0;
      for (int i = 1; i < rows_in_set; i++)
        if (rows[i] < rows[best]) best = i;
      sum = rows[best] + w + pad_in_set;
      if (sum > ROW_SAT) begin
        sum = ROW_SAT;
        saturated++;
      end
      rows[best] = sum[llrp_pkg::ROW_WIDTH_W-1:0];
      p.row    = best[llrp_pkg::ROW_CHOSEN_W-1:0];
      p.width  = sum[llrp_pkg::ROW_WIDTH_W-1:0];
      p.widest = '0;
      p.closes = last;
      if (last) begin
        for (int i = 0; i < rows_in_set; i++)
          if (rows[i] > p.widest) p.widest = rows[i];
        fresh_set = 1'b1;
        sets_closed++;
      end
      pending_placements.insert(pending_placements.size(), p);
      glyphs++;
    endfunction

    function void check_placement(placement_t got);
      placement_t exp_p;
      results++;
      if (pending_placements.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected result beat: row %0d width %0d max %0d final %0b",
                   got.row, got.width, got.widest, got.closes);
        mismatches++;
        return;
      end
      exp_p = pending_placements.pop_front();
      if (got.row !== exp_p.row || got.width !== exp_p.width ||
          got.widest !== exp_p.widest || got.closes !== exp_p.closes) begin
        if (mismatches < 10) begin
          $display("ERROR: result %0d expected row %0d width %0d max %0d final %0b,",
                   results, exp_p.row, exp_p.width, exp_p.widest, exp_p.closes);
          $display("       got row %0d width %0d max %0d final %0b",
                   got.row, got.width, got.widest, got.closes);
        end
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_placements.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [llrp_pkg::GLYPH_W-1:0]      in_glyph_width;
  logic                              in_last_glyph;
  logic                              out_valid;
  logic                              out_stall;
  logic [llrp_pkg::ROW_CHOSEN_W-1:0] out_row_chosen;
  logic [llrp_pkg::ROW_WIDTH_W-1:0]  out_row_width_after;
  logic [llrp_pkg::ROW_WIDTH_W-1:0]  out_max_row_width;
  logic                              out_final_flag;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [llrp_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [31:0]                       cfg_data;

  packing_checker checker_h = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int set_left = 0;
  int cycles = 0;

  least_loaded_row_packer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_glyph_width      (in_glyph_width),
    .in_last_glyph       (in_last_glyph),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_row_chosen      (out_row_chosen),
    .out_row_width_after (out_row_width_after),
    .out_max_row_width   (out_max_row_width),
    .out_final_flag      (out_final_flag),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("ERROR: timeout with %0d placements outstanding", checker_h.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_done) begin
        hold_done++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      checker_h.check_placement({out_row_chosen, out_row_width_after,
                                 out_max_row_width, out_final_flag});
  end

  task automatic send_glyph(input logic [llrp_pkg::GLYPH_W-1:0] w, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_glyph_width <= w;
    in_last_glyph  <= last;
    do @(posedge clk); while (in_stall);
    checker_h.note_glyph(w, last);
  endtask

  // Drop valid and wait for every placement to come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [llrp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    checker_h.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper data bits are junk; the block keeps only the field width
  task automatic set_regs(input int rows, input int pad);
    write_reg(llrp_pkg::REG_ROW_COUNT, ($urandom & ~32'h1F) | rows);
    write_reg(llrp_pkg::REG_PAD_WIDTH, ($urandom & ~32'hFF) | pad);
    if ($urandom_range(0, 1))
      write_reg(llrp_pkg::CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG,
                                                    (1 << llrp_pkg::CFG_IDX_W) - 1)),
                $urandom);
  endtask

  function automatic logic [llrp_pkg::GLYPH_W-1:0] pick_glyph();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GLYPH_MAX;
      2: return llrp_pkg::GLYPH_W'($urandom_range(0, 15));
      default: return llrp_pkg::GLYPH_W'($urandom_range(0, GLYPH_MAX));
    endcase
  endfunction

  // Random glyphs in sets of random length; sets run across phase boundaries
  task automatic send_random(input int count, input int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain();
      if (set_left == 0)
        set_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
                                              : $urandom_range(1, MAX_SET_LEN);
      send_glyph(pick_glyph(), set_left == 1);
      set_left--;
    end
  endtask

  initial begin
    int phase_rows [NUM_PHASES];
    int phase_pad  [NUM_PHASES];

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_glyph_width = '0;
    in_last_glyph  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    phase_rows = '{16, 0, 1, 31, $urandom_range(2, 15), 16, $urandom_range(1, 16)};
    phase_pad  = '{0, 255, 255, 0, $urandom_range(1, 254), 255, $urandom_range(0, 255)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 68;

    // Directed: one row, full padding, widest glyphs until the row saturates
    set_regs(1, 255);
    for (int i = 0; i < 16; i++) send_glyph(GLYPH_MAX, i == 15);
    send_glyph('0, 1'b1);
    drain();

    // Directed: three rows, equal widths so ties go to the lowest index
    set_regs(3, 0);
    send_glyph(llrp_pkg::GLYPH_W'(5), 1'b0);
    send_glyph(llrp_pkg::GLYPH_W'(5), 1'b0);
    send_glyph(llrp_pkg::GLYPH_W'(5), 1'b0);
    send_glyph('0, 1'b0);
    drain();
    // row count beyond the maximum written mid-set: applies from the next set only
    set_regs(31, 7);
    send_glyph(llrp_pkg::GLYPH_W'(1), 1'b1);
    send_glyph(GLYPH_MAX, 1'b1);
    drain();

    // Random phases with changing registers and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 68;
        recv_idle_pct = 33;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(phase_rows[p], phase_pad[p]);
      if (p == 1 || p == 5) hold_req++;
      send_random(PHASE_BEATS, p == 6 ? PHASE_BEATS / 2 : -1);
      drain();
    end

    drain();
    $display("Packed %0d glyphs into %0d closed sets; %0d placements checked, %0d saturated.",
             checker_h.glyphs, checker_h.sets_closed, checker_h.results, checker_h.saturated);
    $display("Mismatches: %0d", checker_h.mismatches);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/llrp_pkg.sv
src/least_loaded_row_packer.sv
tb/least_loaded_row_packer_tb.sv
